// File: sv/serial_loaded_bank_mapper_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial loaded bank mapper
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LOADED_BANK_MAPPER_DEFINES_SVH
`define SERIAL_LOADED_BANK_MAPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SLBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SLBM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SLBM_ASSERT(lbl, prop, msg)
`define SLBM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: sv/slbm_pkg.sv
// ----------------------------------------------------------------------------
// slbm_pkg
// Types and constants shared by the bank mapper modules.
// ----------------------------------------------------------------------------
package slbm_pkg;

  localparam int MAX_PRG_BANKS = 32;
  localparam int MAX_CHR_BANKS = 32;

  localparam int CNT_W     = 6;
  localparam int BANK_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;

  localparam logic [CNT_W-1:0] PRG_COUNT_RESET = 6'd8;
  localparam logic [CNT_W-1:0] CHR_COUNT_RESET = 6'd2;

  localparam logic [4:0] SHIFT_RESET = 5'h10;
  localparam logic [4:0] CTRL_RESET  = 5'h0C;
  localparam logic [4:0] PRG_MODE3   = 5'h0C;

  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG      = 2'd3;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_SRAM = 2'd1;
  localparam logic [1:0] TGT_PRG  = 2'd2;
  localparam logic [1:0] TGT_CHR  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
  } slbm_in_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [18:0] mem_address;
    logic        mem_write;
    logic [7:0]  mem_wdata;
    logic [1:0]  mirror;
  } slbm_out_t;

  typedef struct packed {
    logic       we;
    logic [1:0] sel;
    logic       clear;
    logic       bit_in;
  } slbm_load_t;

  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [3:0] prg_sel;
  } slbm_regs_t;

  typedef struct packed {
    logic              start;
    logic [BANK_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } slbm_mod_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [BANK_W-1:0] rem;
  } slbm_mod_rsp_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: sv/serial_loaded_bank_mapper.sv
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper
// Cartridge bank mapper with serially loaded control registers.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one CPU or PPU
// bus access per beat. Output channel (out_valid_o / out_stall_i /
// out_data_o) returns exactly one result beat per access: target memory,
// mapped address, write strobe and data, and mirroring mode.
// Configuration: cfg_we_i writes cfg_wdata_i into the bank count selected by
// cfg_index_i (0 program banks, 1 character banks); other indexes are ignored.
// Sequencing: a program ROM or character memory access runs the bank index
// through a one-bit-a-cycle remainder unit, five remainder steps, before
// its result goes to the output register; SRAM, unmapped and register load
// accesses go straight to the output register. One access is in flight at
// a time: no new access is taken until the last result is loaded.
// in_stall_o is high from accept until the result is loaded.
// Reset restores bank counts 8 and 2, the shift register marker and PRG
// mode 3. A stalled output holds its beat; the next result waits in the
// sequencer until the output register frees, then input is taken again.
// ----------------------------------------------------------------------------
`include "serial_loaded_bank_mapper_defines.svh"

module serial_loaded_bank_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  slbm_pkg::slbm_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output slbm_pkg::slbm_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [slbm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [slbm_pkg::CNT_W-1:0]          cfg_wdata_i
);
  import slbm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] prg_cnt_q, chr_cnt_q;
  logic [CNT_W-1:0] prg_n, chr_n;
  slbm_in_t         item_q;
  logic [1:0]       tgt_q;
  logic [1:0]       tgt_in;
  logic             accept;
  logic             is_cpu, is_write;
  logic             out_free;
  logic             out_valid_q;
  slbm_out_t        out_q;
  slbm_out_t        result;
  logic [BANK_W-1:0] prg_idx, chr_idx;
  slbm_load_t       load;
  slbm_regs_t       regs;
  slbm_mod_req_t    mod_req;
  slbm_mod_rsp_t    mod_rsp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign is_cpu   = !in_data_i.func[1];
  assign is_write = in_data_i.func[0];

  always_comb begin
    tgt_in = TGT_NONE;
    if (is_cpu) begin
      if (in_data_i.address[15]) begin
        if (!is_write) tgt_in = TGT_PRG;
      end else if (in_data_i.address[14:13] == 2'b11) begin
        tgt_in = TGT_SRAM;
      end
    end else if (in_data_i.address[15:13] == 3'b000) begin
      tgt_in = TGT_CHR;
    end
  end

  assign load.we     = accept && is_cpu && is_write && in_data_i.address[15];
  assign load.sel    = in_data_i.address[14:13];
  assign load.clear  = in_data_i.write_data[7];
  assign load.bit_in = in_data_i.write_data[0];

  slbm_serial_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .regs_o (regs)
  );

  assign prg_n = clamp_count(prg_cnt_q, CNT_W'(MAX_PRG_BANKS));
  assign chr_n = clamp_count(chr_cnt_q, CNT_W'(MAX_CHR_BANKS));

  always_comb begin
    unique case (regs.control[3:2])
      2'd2:    prg_idx = in_data_i.address[14] ? {1'b0, regs.prg_sel} : '0;
      2'd3:    prg_idx = in_data_i.address[14] ? prg_n[BANK_W-1:0] - 1'b1
                                               : {1'b0, regs.prg_sel};
      default: prg_idx = in_data_i.address[14] ? {1'b0, regs.prg_sel | 4'h1}
                                               : {1'b0, regs.prg_sel & 4'hE};
    endcase
    if (!regs.control[4]) begin
      chr_idx = in_data_i.address[12] ? (regs.chr_low | 5'h01)
                                      : (regs.chr_low & 5'h1E);
    end else begin
      chr_idx = in_data_i.address[12] ? regs.chr_high : regs.chr_low;
    end
  end

  assign mod_req.start    = accept && (tgt_in == TGT_PRG || tgt_in == TGT_CHR);
  assign mod_req.dividend = (tgt_in == TGT_PRG) ? prg_idx : chr_idx;
  assign mod_req.divisor  = (tgt_in == TGT_PRG) ? prg_n : chr_n;

  slbm_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_comb begin
    result.target    = tgt_q;
    result.mirror    = regs.control[1:0];
    result.mem_write = item_q.func[0] && (tgt_q == TGT_SRAM || tgt_q == TGT_CHR);
    result.mem_wdata = result.mem_write ? item_q.write_data : '0;
    unique case (tgt_q)
      TGT_SRAM: result.mem_address = {6'b0, item_q.address[12:0]};
      TGT_PRG:  result.mem_address = {mod_rsp.rem, item_q.address[13:0]};
      TGT_CHR:  result.mem_address = {2'b0, mod_rsp.rem, item_q.address[11:0]};
      default:  result.mem_address = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = mod_req.start ? ST_CALC : ST_EMIT;
      ST_CALC: if (mod_rsp.done) state_d = ST_EMIT;
      ST_EMIT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      prg_cnt_q   <= PRG_COUNT_RESET;
      chr_cnt_q   <= CHR_COUNT_RESET;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_PRG_COUNT) prg_cnt_q <= cfg_wdata_i;
        if (cfg_index_i == CFG_CHR_COUNT) chr_cnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      tgt_q  <= tgt_in;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SLBM_ASSERT(a_accept_blocks, accept |=> in_stall_o, "input taken while busy")
  `SLBM_ASSERT(a_done_in_calc, mod_rsp.done |-> (state_q == ST_CALC),
               "remainder done outside calc")
  `SLBM_ASSERT_NEVER(a_mod_idle, (state_q != ST_CALC) && mod_rsp.busy,
                     "remainder unit busy outside calc")
  `SLBM_ASSERT(a_emit_loads, (state_q == ST_EMIT && out_free) |=>
               (out_valid_q && state_q == ST_IDLE), "result beat not loaded")

endmodule

// File: sv/slbm_serial_regs.sv
// ----------------------------------------------------------------------------
// slbm_serial_regs
// Five-bit serial shift register and the bank registers it loads.
// ----------------------------------------------------------------------------
module slbm_serial_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slbm_pkg::slbm_load_t   load_i,
  output slbm_pkg::slbm_regs_t   regs_o
);
  import slbm_pkg::*;

  logic [4:0] shift_q;
  logic [4:0] shift_next;
  slbm_regs_t regs_q;

  assign shift_next = {load_i.bit_in, shift_q[4:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q         <= SHIFT_RESET;
      regs_q.control  <= CTRL_RESET;
      regs_q.chr_low  <= '0;
      regs_q.chr_high <= '0;
      regs_q.prg_sel  <= '0;
    end else if (load_i.we) begin
      if (load_i.clear) begin
        shift_q        <= SHIFT_RESET;
        regs_q.control <= regs_q.control | PRG_MODE3;
      end else if (shift_q[0]) begin
        shift_q <= SHIFT_RESET;
        unique case (load_i.sel)
          SEL_CONTROL:  regs_q.control  <= shift_next;
          SEL_CHR_LOW:  regs_q.chr_low  <= shift_next;
          SEL_CHR_HIGH: regs_q.chr_high <= shift_next;
          SEL_PRG:      regs_q.prg_sel  <= shift_next[3:0];
          default:      regs_q.prg_sel  <= shift_next[3:0];
        endcase
      end else begin
        shift_q <= shift_next;
      end
    end
  end

  assign regs_o = regs_q;

endmodule

// File: sv/slbm_mod_unit.sv
// ----------------------------------------------------------------------------
// slbm_mod_unit
// Restoring remainder unit: bank index modulo bank count, one bit a cycle.
// ----------------------------------------------------------------------------
module slbm_mod_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  slbm_pkg::slbm_mod_req_t req_i,
  output slbm_pkg::slbm_mod_rsp_t rsp_o
);
  import slbm_pkg::*;

  localparam int STEP_W = $clog2(BANK_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [BANK_W-1:0] dvd_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [BANK_W-1:0] rem_q;
  logic [CNT_W-1:0]  trial;

  assign trial = {rem_q, dvd_q[BANK_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(BANK_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, which is at most 32
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[BANK_W-2:0], 1'b0};
      rem_q <= BANK_W'((trial >= dvs_q) ? (trial - dvs_q) : trial);
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: tb/sv/serial_loaded_bank_mapper_tb.sv
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_tb
// Self-checking bench for the serially loaded bank mapper. A directed table
// (reset mapping, address extremes, unmapped accesses, serial register loads)
// runs first. Phases of random bus traffic follow under several bank count
// settings. Every accepted access is mapped by an in-bench copy of the mapper
// state, and each result beat is compared field by field in order.
// ----------------------------------------------------------------------------
module serial_loaded_bank_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slbm_pkg::*;

  localparam logic [1:0] FN_CPU_RD = 2'd0;
  localparam logic [1:0] FN_CPU_WR = 2'd1;
  localparam logic [1:0] FN_PPU_RD = 2'd2;
  localparam logic [1:0] FN_PPU_WR = 2'd3;

  localparam logic [1:0] MIR_ONE_LOW  = 2'd0;
  localparam logic [1:0] MIR_ONE_HIGH = 2'd1;
  localparam logic [1:0] MIR_VERT     = 2'd2;
  localparam logic [1:0] MIR_HORZ     = 2'd3;

  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;
  localparam logic       CHR_MODE_SPLIT     = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [15:0] SRAM_BASE  = 16'h6000;
  localparam logic [15:0] ROM_BASE   = 16'h8000;
  localparam logic [15:0] PPU_LIMIT  = 16'h2000;
  localparam int unsigned PRG_PAGE_BYTES = 'h4000;
  localparam int unsigned CHR_PAGE_BYTES = 'h1000;

  localparam int unsigned LATENCY     = 8;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASE_BEATS = 150;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned CNT_RANDOM  = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic      chk;
    slbm_in_t  acc;
    slbm_out_t res;
  } step_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  slbm_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  slbm_out_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CNT_W-1:0]     cfg_wdata_i = '0;

  // mapper state as the bench sees it
  logic [4:0]       shift_q     = SHIFT_RESET;
  logic [4:0]       control_q   = CTRL_RESET;
  logic [4:0]       chr_low_q   = '0;
  logic [4:0]       chr_high_q  = '0;
  logic [3:0]       prg_sel_q   = '0;
  logic [CNT_W-1:0] prg_count_q = PRG_COUNT_RESET;
  logic [CNT_W-1:0] chr_count_q = CHR_COUNT_RESET;

  slbm_out_t   mapped_q[$];
  step_row_t   steps[$];
  int unsigned mismatches    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned hold_left     = 0;
  bit          calm          = 1'b0;
  bit          long_hold_req = 1'b0;
  slbm_out_t   want;

  serial_loaded_bank_mapper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned pick_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Maps one access and advances the serial load state.
  task automatic map_access(input slbm_in_t a, output slbm_out_t r);
    int unsigned n;
    int unsigned bank;
    logic        done;
    r = '0;
    if (!a.func[1]) begin
      if (a.address >= ROM_BASE) begin
        if (a.func[0]) begin
          if (a.write_data[7]) begin
            shift_q   = SHIFT_RESET;
            control_q = control_q | PRG_MODE3;
          end else begin
            done    = shift_q[0];
            shift_q = {a.write_data[0], shift_q[4:1]};
            if (done) begin
              case (a.address[14:13])
                SEL_CONTROL:  control_q  = shift_q;
                SEL_CHR_LOW:  chr_low_q  = shift_q;
                SEL_CHR_HIGH: chr_high_q = shift_q;
                default:      prg_sel_q  = shift_q[3:0];
              endcase
              shift_q = SHIFT_RESET;
            end
          end
        end else begin
          n = (prg_count_q == 0) ? 1 :
              (prg_count_q > MAX_PRG_BANKS) ? MAX_PRG_BANKS : prg_count_q;
          case (control_q[3:2])
            PRG_MODE_FIX_FIRST: bank = a.address[14] ? prg_sel_q : 0;
            PRG_MODE_FIX_LAST:  bank = a.address[14] ? n - 1 : prg_sel_q;
            default:            bank = a.address[14] ? (prg_sel_q | 4'h1) : (prg_sel_q & 4'hE);
          endcase
          r.target      = TGT_PRG;
          r.mem_address = 19'((bank % n) * PRG_PAGE_BYTES + a.address[13:0]);
        end
      end else if (a.address >= SRAM_BASE) begin
        r.target      = TGT_SRAM;
        r.mem_address = 19'(a.address - SRAM_BASE);
        r.mem_write   = a.func[0];
      end
    end else if (a.address < PPU_LIMIT) begin
      n = (chr_count_q == 0) ? 1 :
          (chr_count_q > MAX_CHR_BANKS) ? MAX_CHR_BANKS : chr_count_q;
      if (control_q[4] == CHR_MODE_SPLIT) begin
        bank = a.address[12] ? chr_high_q : chr_low_q;
      end else begin
        bank = a.address[12] ? (chr_low_q | 5'h01) : (chr_low_q & 5'h1E);
      end
      r.target      = TGT_CHR;
      r.mem_address = 19'((bank % n) * CHR_PAGE_BYTES + a.address[11:0]);
      r.mem_write   = a.func[0];
    end
    if (r.mem_write) begin
      r.mem_wdata = a.write_data;
    end
    r.mirror = control_q[1:0];
  endtask

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_access(input slbm_in_t a, input logic fixed, input slbm_out_t fixed_res);
    int unsigned gap;
    slbm_out_t   predicted;
    gap = pick_wait();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = a;
    do @(posedge clk_i); while (in_stall_o);
    map_access(a, predicted);
    mapped_q.push_back(fixed ? fixed_res : predicted);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (mapped_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_PRG_COUNT) begin
      prg_count_q = val;
    end else if (idx == CFG_CHR_COUNT) begin
      chr_count_q = val;
    end
  endtask

  task automatic add_check(input logic [1:0] fn, input logic [15:0] addr, input logic [7:0] data,
                           input logic [1:0] tgt, input logic [18:0] maddr, input logic wr,
                           input logic [7:0] wdata, input logic [1:0] mir);
    step_row_t s;
    s.chk                 = 1'b1;
    s.acc.func            = fn;
    s.acc.address         = addr;
    s.acc.write_data      = data;
    s.res.target          = tgt;
    s.res.mem_address     = maddr;
    s.res.mem_write       = wr;
    s.res.mem_wdata       = wdata;
    s.res.mirror          = mir;
    steps.push_back(s);
  endtask

  task automatic add_step(input logic [1:0] fn, input logic [15:0] addr, input logic [7:0] data);
    step_row_t s;
    s                = '0;
    s.acc.func       = fn;
    s.acc.address    = addr;
    s.acc.write_data = data;
    steps.push_back(s);
  endtask

  task automatic random_traffic(input int unsigned beats);
    int unsigned sent;
    slbm_in_t    a;
    logic [1:0]  sel;
    sent = 0;
    while (sent < beats) begin
      if (sent % 50 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) == 0) begin
        drain_results();
      end
      if ($urandom_range(0, 9) < 4) begin
        // five-write register load, sometimes broken by a clear or a read
        sel = 2'($urandom);
        for (int k = 0; k < 5; k++) begin
          a.func       = FN_CPU_WR;
          a.address    = {1'b1, sel, 13'($urandom)};
          a.write_data = 8'($urandom) & 8'h7F;
          if ($urandom_range(0, 19) == 0) begin
            a.write_data[7] = 1'b1;
          end
          send_access(a, 1'b0, '0);
          sent++;
          if ($urandom_range(0, 5) == 0) begin
            a.func       = 2'($urandom_range(0, 1)) << 1;
            a.address    = 16'($urandom);
            a.write_data = 8'($urandom);
            send_access(a, 1'b0, '0);
            sent++;
          end
        end
      end else begin
        a.write_data = 8'($urandom);
        case ($urandom_range(0, 3))
          0: begin
            a.address = {1'b1, 15'($urandom)};
            a.func    = ($urandom_range(0, 7) == 0) ? 2'($urandom) : FN_CPU_RD;
          end
          1: begin
            a.address = {3'b011, 13'($urandom)};
            a.func    = {1'b0, 1'($urandom)};
          end
          2: begin
            a.address = {3'b000, 13'($urandom)};
            a.func    = ($urandom_range(0, 7) == 0) ? 2'($urandom) : {1'b1, 1'($urandom)};
          end
          default: begin
            a.address = 16'($urandom);
            a.func    = 2'($urandom);
          end
        endcase
        send_access(a, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mapped_q.size() == 0) begin
        $error("unexpected result beat: %p", out_data_o);
        mismatches++;
      end else begin
        want = mapped_q.pop_front();
        if (out_data_o.target !== want.target) begin
          $error("target: expected %0d, got %0d", want.target, out_data_o.target);
          mismatches++;
        end
        if (out_data_o.mem_address !== want.mem_address) begin
          $error("mem_address: expected 0x%05h, got 0x%05h", want.mem_address,
                 out_data_o.mem_address);
          mismatches++;
        end
        if (out_data_o.mem_write !== want.mem_write) begin
          $error("mem_write: expected %0d, got %0d", want.mem_write, out_data_o.mem_write);
          mismatches++;
        end
        if (out_data_o.mem_wdata !== want.mem_wdata) begin
          $error("mem_wdata: expected 0x%02h, got 0x%02h", want.mem_wdata, out_data_o.mem_wdata);
          mismatches++;
        end
        if (out_data_o.mirror !== want.mirror) begin
          $error("mirror: expected %0d, got %0d", want.mirror, out_data_o.mirror);
          mismatches++;
        end
      end
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (rst_ni && out_valid_o && !out_stall_i) begin
        hold_left = pick_wait();
      end
      @(negedge clk_i);
      out_stall_i = (hold_left != 0);
      if (hold_left != 0) begin
        hold_left--;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("serial_loaded_bank_mapper regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned prg_plan[NUM_PHASES];
    int unsigned chr_plan[NUM_PHASES];
    prg_plan = '{8, 1, 32, 0, 63, 2, 33, CNT_RANDOM, CNT_RANDOM, 16};
    chr_plan = '{2, 1, 32, 0, 63, 4, 17, CNT_RANDOM, CNT_RANDOM, 31};

    // reset state: PRG mode 3, 8 PRG banks, 2 CHR banks
    add_check(FN_CPU_RD, 16'h8000, 8'h00, TGT_PRG,  19'h00000, 1'b0, 8'h00, MIR_ONE_LOW);
    add_check(FN_CPU_RD, 16'hFFFF, 8'hFF, TGT_PRG,  19'h1FFFF, 1'b0, 8'h00, MIR_ONE_LOW);
    add_check(FN_CPU_RD, 16'hC000, 8'h00, TGT_PRG,  19'h1C000, 1'b0, 8'h00, MIR_ONE_LOW);
    add_check(FN_CPU_RD, 16'h6000, 8'h00, TGT_SRAM, 19'h00000, 1'b0, 8'h00, MIR_ONE_LOW);
    add_check(FN_CPU_WR, 16'h7FFF, 8'hA5, TGT_SRAM, 19'h01FFF, 1'b1, 8'hA5, MIR_ONE_LOW);
    add_check(FN_CPU_RD, 16'h5FFF, 8'h00, TGT_NONE, 19'h00000, 1'b0, 8'h00, MIR_ONE_LOW);
    add_check(FN_CPU_WR, 16'h0000, 8'hFF, TGT_NONE, 19'h00000, 1'b0, 8'h00, MIR_ONE_LOW);
    add_check(FN_PPU_RD, 16'h0000, 8'h00, TGT_CHR,  19'h00000, 1'b0, 8'h00, MIR_ONE_LOW);
    add_check(FN_PPU_WR, 16'h1FFF, 8'h5A, TGT_CHR,  19'h01FFF, 1'b1, 8'h5A, MIR_ONE_LOW);
    add_check(FN_PPU_RD, 16'h2000, 8'h00, TGT_NONE, 19'h00000, 1'b0, 8'h00, MIR_ONE_LOW);
    add_check(FN_PPU_WR, 16'hFFFF, 8'h33, TGT_NONE, 19'h00000, 1'b0, 8'h00, MIR_ONE_LOW);
    add_check(FN_CPU_WR, 16'h8000, 8'h80, TGT_NONE, 19'h00000, 1'b0, 8'h00, MIR_ONE_LOW);
    // control <= 5'b10010: split CHR, 32KB PRG, vertical
    add_step(FN_CPU_WR, 16'h8000, 8'h7E);
    add_step(FN_CPU_WR, 16'h9FFF, 8'h01);
    add_step(FN_CPU_WR, 16'h8123, 8'h00);
    add_step(FN_CPU_WR, 16'h9000, 8'h7E);
    add_step(FN_CPU_WR, 16'h8000, 8'h7F);
    // prg select <= 5
    add_step(FN_CPU_WR, 16'hE000, 8'h01);
    add_step(FN_CPU_WR, 16'hE001, 8'h00);
    add_step(FN_CPU_WR, 16'hFFFF, 8'h01);
    add_step(FN_CPU_WR, 16'hF000, 8'h40);
    add_step(FN_CPU_WR, 16'hE000, 8'h00);
    add_step(FN_CPU_RD, 16'h8000, 8'h00);
    add_step(FN_CPU_RD, 16'hC000, 8'h00);
    // partial load cut short by a clear, then last bank fixed again
    add_step(FN_CPU_WR, 16'hA000, 8'h01);
    add_step(FN_CPU_WR, 16'hC000, 8'hC0);
    add_step(FN_CPU_RD, 16'hC000, 8'h00);

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (steps[i]) begin
      send_access(steps[i].acc, steps[i].chk, steps[i].res);
    end

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      repeat (LATENCY) @(negedge clk_i);
      if (p > 0) begin
        write_reg(CFG_PRG_COUNT, (prg_plan[p] == CNT_RANDOM) ?
                  CNT_W'($urandom_range(0, 63)) : CNT_W'(prg_plan[p]));
        write_reg(CFG_CHR_COUNT, (chr_plan[p] == CNT_RANDOM) ?
                  CNT_W'($urandom_range(0, 63)) : CNT_W'(chr_plan[p]));
        if (p % 3 == 1) begin
          write_reg(CFG_SPARE_A, CNT_W'($urandom));
          write_reg(CFG_SPARE_B, CNT_W'($urandom));
        end
      end
      if (p == 2) begin
        long_hold_req = 1'b1;
      end
      random_traffic(PHASE_BEATS);
    end

    drain_results();
    repeat (4 * LATENCY) @(negedge clk_i);
    if (mismatches == 0 && mapped_q.size() == 0) begin
      $display("serial_loaded_bank_mapper regression: pass");
    end else begin
      $display("serial_loaded_bank_mapper regression: fail");
    end
    $finish;
  end

endmodule
